// ===== rtl/gdma_pkg.sv =====
`default_nettype none

package gdma_pkg;

  // Window depth used when the top level is not overridden.
  localparam int unsigned WINDOW_DEFAULT = 10;

  // Field widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MM_W      = 16;
  localparam int unsigned DIST_W    = 13;
  localparam int unsigned DIST_MAX  = 6553;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned RUN_W     = 7;
  localparam int unsigned AVG_W     = 16;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = 32;

  // floor(mm / 10) for any 16-bit mm is (mm * 52429) >> 19.
  localparam logic [MM_W-1:0] MM_RECIP = 16'd52429;
  localparam int unsigned     MM_SHIFT = 19;

  // Register reset values.
  localparam logic [DIST_W-1:0] LOWER_RESET    = 13'd10;
  localparam logic [DIST_W-1:0] UPPER_RESET    = 13'd100;
  localparam logic [MS_W-1:0]   START_RESET    = 16'd60;
  localparam logic [MS_W-1:0]   STOP_RESET     = 16'd5000;
  localparam logic [MS_W-1:0]   INTERVAL_RESET = 16'd60;
  localparam logic [CNT_W-1:0]  RAMP_RESET     = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER = 2'd0,
    CFG_UPPER = 2'd1,
    CFG_START = 2'd2,
    CFG_STOP  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_ACCEPT = 2'd0,
    CLS_NEAR   = 2'd1,
    CLS_FAR    = 2'd2
  } cls_e;

endpackage

`default_nettype wire

// ===== rtl/gdma_cell.sv =====
`default_nettype none

module gdma_cell
  import gdma_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              shift_i,
  input  wire logic [DIST_W-1:0] data_i,
  output logic      [DIST_W-1:0] data_o
);

  logic [DIST_W-1:0] data_q;

  // One window entry; it takes its neighbor's value whenever a reading is kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/gated_distance_moving_average.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_ready_o   range_high_byte_i, range_low_byte_i
// result    out        out_valid_o / out_ready_i distance_whole_cm_o ... ramp_step_o
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One reading enters per cycle unless the output stalls; results pass the input, gating,
// scaling and output registers in turn. The gating stage updates the window, the running sum
// and the interval ramp together, and shifts the cell chain once per kept reading.
// Reset clears the window cells, all counters and the pipeline; registers take their defaults.
// A stalled output only blocks as far back as the next empty stage, so bubbles are absorbed.

module gated_distance_moving_average
  import gdma_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,

  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [BYTE_W-1:0]    range_high_byte_i,
  input  wire logic [BYTE_W-1:0]    range_low_byte_i,

  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [DIST_W-1:0]    distance_whole_cm_o,
  output logic      [1:0]           reading_class_o,
  output logic      [AVG_W-1:0]     average_tenths_cm_o,
  output logic                      average_valid_o,
  output logic      [CNT_W-1:0]     too_near_total_o,
  output logic      [CNT_W-1:0]     too_far_total_o,
  output logic      [MS_W-1:0]      next_interval_ms_o,
  output logic      [CNT_W-1:0]     ramp_step_o
);

  // The running sum must hold WINDOW full-scale readings.
  localparam int unsigned TOTAL_W = $clog2(WINDOW * DIST_MAX + 1);
  // The average is floor(total * 10 / WINDOW). The product total * 10 is taken
  // times a rounded-up reciprocal of WINDOW; the extra WLOG fraction bits keep
  // the rounding error below 1 / WINDOW, so the floor is exact.
  localparam int unsigned XW   = TOTAL_W + 4;
  localparam int unsigned WLOG = $clog2(WINDOW);
  localparam int unsigned SH   = XW + WLOG;
  localparam int unsigned MW   = XW + 1;
  localparam int unsigned PW   = SH + AVG_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MW-1:0] RECIP = RECIP_WIDE[MW-1:0];
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(WINDOW * DIST_MAX);

  // What a result carries from the gating stage to the output register.
  typedef struct packed {
    logic [DIST_W-1:0] dist_cm;
    cls_e              cls;
    logic              avg_valid;
    logic [CNT_W-1:0]  near;
    logic [CNT_W-1:0]  far;
    logic [MS_W-1:0]   interval;
    logic [CNT_W-1:0]  ramp;
  } rslt_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must come only while the block is idle (not enforced).
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0] lower_q;
  logic [DIST_W-1:0] upper_q;
  logic [MS_W-1:0]   start_q;
  logic [MS_W-1:0]   stop_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RESET;
      upper_q <= UPPER_RESET;
      start_q <= START_RESET;
      stop_q  <= STOP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LOWER: lower_q <= cfg_data_i[DIST_W-1:0];
        CFG_UPPER: upper_q <= cfg_data_i[DIST_W-1:0];
        CFG_START: start_q <= cfg_data_i;
        CFG_STOP:  stop_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshakes. Each stage loads when it is empty or when its item moves on.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic move12, move23, move34;

  assign rdy4   = !vo_q || out_ready_i;
  assign rdy3   = !v3_q || rdy4;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign move12 = v1_q && rdy2;
  assign move23 = v2_q && rdy3;
  assign move34 = v3_q && rdy4;

  assign in_ready_o  = rdy1;
  assign out_valid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        vo_q <= v3_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: millimetres to whole centimetres by reciprocal multiplication.
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] mm_prod;
  logic [DIST_W-1:0] d1_q;

  assign mm_prod = PROD_W'({range_high_byte_i, range_low_byte_i}) * PROD_W'(MM_RECIP);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      d1_q <= mm_prod[MM_SHIFT +: DIST_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: gate the reading and update all running state once per item.
  // ---------------------------------------------------------------------------
  logic               keep;
  logic               near_hit;
  logic               shift_en;
  logic [DIST_W-1:0]  tap [WINDOW];
  logic [DIST_W-1:0]  oldest;

  logic [TOTAL_W-1:0] total_q, total_d;
  logic [RUN_W-1:0]   run_q, run_d, run_inc;
  logic [CNT_W-1:0]   near_q, near_d;
  logic [CNT_W-1:0]   far_q, far_d;
  logic [MS_W-1:0]    interval_q, interval_d;
  logic [CNT_W-1:0]   ramp_q, ramp_d;
  logic [PROD_W-1:0]  ramp_prod;
  cls_e               cls_d;
  logic               avg_valid_d;

  assign keep     = (d1_q > lower_q) && (d1_q < upper_q);
  assign near_hit = (d1_q <= lower_q);
  assign shift_en = move12 && keep;

  // The window is a chain of cells: a kept reading enters at the head and the
  // entry falling off the tail is the oldest one, which leaves the running sum.
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      gdma_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift_en),
        .data_i (d1_q),
        .data_o (tap[k])
      );
    end else begin : g_body
      gdma_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift_en),
        .data_i (tap[k-1]),
        .data_o (tap[k])
      );
    end
  end

  assign oldest    = tap[WINDOW-1];
  assign run_inc   = (run_q == '1) ? run_q : run_q + RUN_W'(1);
  assign ramp_prod = PROD_W'(start_q) * PROD_W'(ramp_q);

  always_comb begin
    total_d     = total_q;
    run_d       = run_q;
    near_d      = near_q;
    far_d       = far_q;
    interval_d  = interval_q;
    ramp_d      = ramp_q;
    avg_valid_d = 1'b0;
    if (keep) begin
      cls_d       = CLS_ACCEPT;
      total_d     = total_q - TOTAL_W'(oldest) + TOTAL_W'(d1_q);
      run_d       = run_inc;
      avg_valid_d = (run_inc >= RUN_W'(WINDOW));
      // The ramp restarts at the base interval once the product reaches the stop value.
      if (ramp_prod >= PROD_W'(stop_q)) begin
        interval_d = start_q;
        ramp_d     = RAMP_RESET;
      end else begin
        interval_d = ramp_prod[MS_W-1:0];
        ramp_d     = (ramp_q == '1) ? ramp_q : ramp_q + CNT_W'(1);
      end
    end else if (near_hit) begin
      cls_d  = CLS_NEAR;
      run_d  = '0;
      near_d = (near_q == '1) ? near_q : near_q + CNT_W'(1);
    end else begin
      cls_d  = CLS_FAR;
      run_d  = '0;
      far_d  = (far_q == '1) ? far_q : far_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      run_q      <= '0;
      near_q     <= '0;
      far_q      <= '0;
      interval_q <= INTERVAL_RESET;
      ramp_q     <= RAMP_RESET;
    end else if (move12) begin
      total_q    <= total_d;
      run_q      <= run_d;
      near_q     <= near_d;
      far_q      <= far_d;
      interval_q <= interval_d;
      ramp_q     <= ramp_d;
    end
  end

  rslt_t              r2_q;
  logic [TOTAL_W-1:0] total2_q;

  always_ff @(posedge clk_i) begin
    if (move12) begin
      r2_q.dist_cm   <= d1_q;
      r2_q.cls       <= cls_d;
      r2_q.avg_valid <= avg_valid_d;
      r2_q.near      <= near_d;
      r2_q.far       <= far_d;
      r2_q.interval  <= interval_d;
      r2_q.ramp      <= ramp_d;
      total2_q       <= total_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale the sum by ten with a shift and add.
  // ---------------------------------------------------------------------------
  rslt_t         r3_q;
  logic [XW-1:0] x3_q;

  always_ff @(posedge clk_i) begin
    if (move23) begin
      r3_q <= r2_q;
      x3_q <= (XW'(total2_q) << 3) + (XW'(total2_q) << 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: divide by WINDOW through the reciprocal and load the output register.
  // The average register keeps its value across rejected readings.
  // ---------------------------------------------------------------------------
  logic [PW-1:0]    avg_prod;
  rslt_t            ro_q;
  logic [AVG_W-1:0] avg_q;

  assign avg_prod = PW'(x3_q) * PW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (move34 && (r3_q.cls == CLS_ACCEPT)) begin
      avg_q <= avg_prod[SH +: AVG_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (move34) begin
      ro_q <= r3_q;
    end
  end

  assign distance_whole_cm_o = ro_q.dist_cm;
  assign reading_class_o     = ro_q.cls;
  assign average_tenths_cm_o = avg_q;
  assign average_valid_o     = ro_q.avg_valid;
  assign too_near_total_o    = ro_q.near;
  assign too_far_total_o     = ro_q.far;
  assign next_interval_ms_o  = ro_q.interval;
  assign ramp_step_o         = ro_q.ramp;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_valid_only_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && average_valid_o |-> reading_class_o == CLS_ACCEPT)
    else $error("average valid reported on a rejected reading");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOTAL_MAX)
    else $error("running sum exceeds a full window of maximum readings");

  a_stage2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !rdy3 |=> v2_q && $stable(r2_q) && $stable(total2_q))
    else $error("stage 2 item lost or changed while stalled");

  a_near_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> near_q == $past(near_q) || near_q == $past(near_q) + CNT_W'(1))
    else $error("too-near counter moved by more than one");

  a_ramp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_q != '0)
    else $error("ramp multiplier reached zero");

endmodule

`default_nettype wire

// ===== bench/gated_distance_moving_average_tb.sv =====
`default_nettype none

// Self-checking bench for the range-gated moving average.
// Readings go in as two bytes of millimetres. A tracker object mirrors the
// window, the running sum, the reject counters and the interval ramp. Every
// accepted input transaction gets its expected result queued, and every
// output transaction is checked against the oldest queued one.

module gated_distance_moving_average_tb;
  import gdma_pkg::*;

  localparam int unsigned WINDOW         = WINDOW_DEFAULT;
  localparam int unsigned SUM_W          = 17;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  // Wait after the last owed result so that the pipeline is empty.
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned PHASE_READINGS = 70;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [DIST_W-1:0] dist_cm;
    cls_e              cls;
    logic [AVG_W-1:0]  avg_tenths;
    logic              avg_ok;
    logic [CNT_W-1:0]  near_total;
    logic [CNT_W-1:0]  far_total;
    logic [MS_W-1:0]   interval;
    logic [CNT_W-1:0]  step;
  } reading_result_t;

  // Mirrors the filter state and holds the results still owed by the block.
  class range_average_tracker;
    logic [DIST_W-1:0] lower_cm;
    logic [DIST_W-1:0] upper_cm;
    logic [MS_W-1:0]   start_ms;
    logic [MS_W-1:0]   stop_ms;
    logic [DIST_W-1:0] window_cells [WINDOW];
    int unsigned       next_slot;
    logic [SUM_W-1:0]  window_sum;
    logic [RUN_W-1:0]  good_streak;
    logic [CNT_W-1:0]  near_seen;
    logic [CNT_W-1:0]  far_seen;
    logic [MS_W-1:0]   interval_ms;
    logic [CNT_W-1:0]  ramp_mult;
    logic [SUM_W-1:0]  avg_hold;
    reading_result_t   pending_results [$];
    int unsigned       failures;

    function new();
      lower_cm    = LOWER_RESET;
      upper_cm    = UPPER_RESET;
      start_ms    = START_RESET;
      stop_ms     = STOP_RESET;
      foreach (window_cells[i]) window_cells[i] = '0;
      next_slot   = 0;
      window_sum  = '0;
      good_streak = '0;
      near_seen   = '0;
      far_seen    = '0;
      interval_ms = INTERVAL_RESET;
      ramp_mult   = RAMP_RESET;
      avg_hold    = '0;
      failures    = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_LOWER: lower_cm = data[DIST_W-1:0];
        CFG_UPPER: upper_cm = data[DIST_W-1:0];
        CFG_START: start_ms = data;
        CFG_STOP:  stop_ms  = data;
        default: ;
      endcase
    endfunction

    function void note_reading(logic [BYTE_W-1:0] high_byte, logic [BYTE_W-1:0] low_byte);
      logic [MM_W-1:0] mm;
      logic [31:0]     prod;
      int unsigned     slot;
      reading_result_t r;
      mm = {high_byte, low_byte};
      r = '0;
      r.dist_cm = DIST_W'(mm / 10);
      if (good_streak != '1) good_streak++;
      if (r.dist_cm > lower_cm && r.dist_cm < upper_cm) begin
        slot = (next_slot < WINDOW) ? next_slot : 0;
        r.cls = CLS_ACCEPT;
        window_sum = window_sum - window_cells[slot] + r.dist_cm;
        window_cells[slot] = r.dist_cm;
        next_slot = (slot + 1) % WINDOW;
        avg_hold = SUM_W'((32'(window_sum) * 32'd10) / WINDOW);
        r.avg_ok = (good_streak >= WINDOW);
        prod = 32'(start_ms) * 32'(ramp_mult);
        if (prod >= 32'(stop_ms)) begin
          interval_ms = start_ms;
          ramp_mult = RAMP_RESET;
        end else begin
          interval_ms = prod[MS_W-1:0];
          if (ramp_mult != '1) ramp_mult++;
        end
      end else if (r.dist_cm <= lower_cm) begin
        r.cls = CLS_NEAR;
        if (near_seen != '1) near_seen++;
        good_streak = '0;
      end else begin
        r.cls = CLS_FAR;
        if (far_seen != '1) far_seen++;
        good_streak = '0;
      end
      r.avg_tenths = avg_hold[AVG_W-1:0];
      r.near_total = near_seen;
      r.far_total  = far_seen;
      r.interval   = interval_ms;
      r.step       = ramp_mult;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(reading_result_t got);
      reading_result_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction with no reading waiting for it");
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("distance_whole_cm", want.dist_cm, got.dist_cm);
      compare_field("reading_class", want.cls, got.cls);
      compare_field("average_tenths_cm", want.avg_tenths, got.avg_tenths);
      compare_field("average_valid", want.avg_ok, got.avg_ok);
      compare_field("too_near_total", want.near_total, got.near_total);
      compare_field("too_far_total", want.far_total, got.far_total);
      compare_field("next_interval_ms", want.interval, got.interval);
      compare_field("ramp_step", want.step, got.step);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [BYTE_W-1:0]    range_high_byte_i;
  logic [BYTE_W-1:0]    range_low_byte_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [DIST_W-1:0]    distance_whole_cm_o;
  logic [1:0]           reading_class_o;
  logic [AVG_W-1:0]     average_tenths_cm_o;
  logic                 average_valid_o;
  logic [CNT_W-1:0]     too_near_total_o;
  logic [CNT_W-1:0]     too_far_total_o;
  logic [MS_W-1:0]      next_interval_ms_o;
  logic [CNT_W-1:0]     ramp_step_o;

  range_average_tracker tracker;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int unsigned sender_pct;
  int unsigned receiver_pct;
  int unsigned cycle_count;

  gated_distance_moving_average #(
    .WINDOW(WINDOW)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .range_high_byte_i  (range_high_byte_i),
    .range_low_byte_i   (range_low_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .distance_whole_cm_o(distance_whole_cm_o),
    .reading_class_o    (reading_class_o),
    .average_tenths_cm_o(average_tenths_cm_o),
    .average_valid_o    (average_valid_o),
    .too_near_total_o   (too_near_total_o),
    .too_far_total_o    (too_far_total_o),
    .next_interval_ms_o (next_interval_ms_o),
    .ramp_step_o        (ramp_step_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit hold_off(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // The receiver decides its ready for the coming edge at each falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= !hold_off(receiver_pct);
  end

  // Output transactions are sampled at the rising edge, before the block updates.
  always @(posedge clk_i) begin : result_monitor
    reading_result_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.dist_cm    = distance_whole_cm_o;
      seen.cls        = cls_e'(reading_class_o);
      seen.avg_tenths = average_tenths_cm_o;
      seen.avg_ok     = average_valid_o;
      seen.near_total = too_near_total_o;
      seen.far_total  = too_far_total_o;
      seen.interval   = next_interval_ms_o;
      seen.step       = ramp_step_o;
      tracker.check_result(seen);
    end
  end

  // Watchdog. The slowest correct run stays far below this limit.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Called at a falling edge. Valid is lowered only when the sender idles, so
  // back-to-back readings keep valid high with no glitch between them.
  task automatic send_reading(input logic [BYTE_W-1:0] high_byte,
                              input logic [BYTE_W-1:0] low_byte);
    while (hold_off(sender_pct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    range_high_byte_i <= high_byte;
    range_low_byte_i  <= low_byte;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_reading(high_byte, low_byte);
    @(negedge clk_i);
  endtask

  task automatic send_mm(input logic [MM_W-1:0] mm);
    send_reading(mm[MM_W-1:BYTE_W], mm[BYTE_W-1:0]);
  endtask

  // Any millimetre value that floors to the given centimetre count.
  task automatic send_cm(input int unsigned cm);
    send_mm(MM_W'(cm * 10 + $urandom_range(0, (cm >= DIST_MAX) ? 5 : 9)));
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_register(idx, data);
    @(negedge clk_i);
  endtask

  // Waits until every owed result has come back, then lets the pipeline empty.
  task automatic settle();
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly bursts of in-band readings, which fill the window and walk the ramp,
  // broken up by too-near, too-far and raw random readings. A long burst now
  // and then drives the run of good readings into saturation.
  task automatic run_random(input int unsigned count);
    int unsigned     sent;
    int unsigned     burst;
    logic [MM_W-1:0] noise;
    sent = 0;
    while (sent < count) begin
      if (tracker.upper_cm > tracker.lower_cm + 1) begin
        burst = ($urandom_range(0, 5) == 0) ? 135 : $urandom_range(1, 30);
        repeat (burst) begin
          send_cm($urandom_range(tracker.lower_cm + 1, tracker.upper_cm - 1));
          sent++;
        end
      end
      case ($urandom_range(0, 2))
        0: send_cm($urandom_range(0, (tracker.lower_cm > DIST_MAX) ? DIST_MAX
                                                                    : tracker.lower_cm));
        1: send_cm((tracker.upper_cm > DIST_MAX) ? DIST_MAX
                                                 : $urandom_range(tracker.upper_cm, DIST_MAX));
        default: begin
          noise = MM_W'($urandom);
          send_mm(noise);
        end
      endcase
      sent++;
    end
    in_valid_i <= 1'b0;
    settle();
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin sender_pct = 88; receiver_pct = 0;  end
      IDLE_RECEIVER: begin sender_pct = 0;  receiver_pct = 88; end
      IDLE_BOTH:     begin sender_pct = 29; receiver_pct = 29; end
      default:       begin sender_pct = 0;  receiver_pct = 0;  end
    endcase
  endtask

  // One phase: new register values while the block is idle, then random readings.
  task automatic run_phase(input idle_mode_e mode,
                           input logic [CFG_W-1:0] lower, input logic [CFG_W-1:0] upper,
                           input logic [CFG_W-1:0] start, input logic [CFG_W-1:0] stop);
    set_idle(mode);
    write_register(CFG_LOWER, lower);
    write_register(CFG_UPPER, upper);
    write_register(CFG_START, start);
    write_register(CFG_STOP, stop);
    cfg_valid_i <= 1'b0;
    run_random(PHASE_READINGS);
  endtask

  initial begin : stimulus
    int unsigned cm_a;
    int unsigned cm_b;
    tracker           = new();
    sender_pct        = 0;
    receiver_pct      = 0;
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = CFG_LOWER;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    range_high_byte_i = '0;
    range_low_byte_i  = '0;
    out_ready_i       = 1'b0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed readings under the reset limits of 10 and 100 cm.
    set_idle(IDLE_NONE);
    send_reading(8'h00, 8'h00);    // zero distance, too near
    send_reading(8'hFF, 8'hFF);    // largest reading, too far
    send_mm(16'd109);              // floors to the lower limit itself: too near
    send_mm(16'd110);              // one above the lower limit: accepted
    send_mm(16'd999);              // one below the upper limit: accepted
    send_mm(16'd1000);             // the upper limit itself: too far
    // A full window of good readings raises the average-valid flag.
    for (int k = 0; k < 12; k++) send_mm(MM_W'(110 + k * 73));
    send_mm(16'd5);                // a reject clears the good run again
    send_reading(8'hAA, 8'h55);
    send_reading(8'h55, 8'hAA);
    run_random(PHASE_READINGS);

    // Widest band; the ramp counts up one by one toward a far stop.
    run_phase(IDLE_SENDER, 16'd0, 16'd6553, 16'd1, 16'd65535);
    // Crossed limits: nothing is accepted, the near test wins.
    run_phase(IDLE_RECEIVER, 16'd6553, 16'd0, 16'd65535, 16'd1);
    // Equal limits: again nothing is accepted.
    run_phase(IDLE_BOTH, 16'd50, 16'd50, 16'd300, 16'd4000);
    // Two-value band; the largest step reaches the stop at once.
    run_phase(IDLE_NONE, 16'd20, 16'd23, 16'd65535, 16'd65535);
    // Single-value band with a zero step: the product never reaches the stop.
    run_phase(IDLE_SENDER, 16'd0, 16'd2, 16'd0, 16'd1000);

    // Random settings, limits sorted so that most readings can pass.
    for (int p = 0; p < 2; p++) begin
      cm_a = $urandom_range(0, DIST_MAX);
      cm_b = $urandom_range(0, DIST_MAX);
      run_phase((p == 0) ? IDLE_RECEIVER : IDLE_BOTH,
                CFG_W'((cm_a < cm_b) ? cm_a : cm_b), CFG_W'((cm_a < cm_b) ? cm_b : cm_a),
                CFG_W'($urandom_range(1, 400)), CFG_W'($urandom_range(1, 65535)));
    end

    // Upper data bits of the limit writes lie beyond the 13-bit registers and drop.
    run_phase(IDLE_NONE, 16'hE005, 16'h6BB8, 16'd3000, 16'd40000);

    if (tracker.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== gated_distance_moving_average.f =====
rtl/gdma_pkg.sv
rtl/gdma_cell.sv
rtl/gated_distance_moving_average.sv
bench/gated_distance_moving_average_tb.sv
